// ----- rtl/bpmp_pkg.sv -----
// Shared types and constants for the bone palette mesh partitioner.
// Used by bpmp_ctrl, bpmp_dp and the top level; depends on nothing.
package bpmp_pkg;

    localparam int unsigned NUM_CORNERS  = 3;
    localparam int unsigned SLOT_LANES   = 4;
    localparam int unsigned NUM_SLOTS    = NUM_CORNERS * SLOT_LANES;
    localparam int unsigned SERIAL_W     = 16;
    localparam int unsigned LOCAL_W      = 7;
    localparam int unsigned PALETTE_CAP  = 128;
    localparam int unsigned LIMIT_RESET  = 128;
    localparam int unsigned VCOUNT_W     = 17;
    localparam int unsigned VCOUNT_SAT   = 65536;
    localparam int unsigned PALETTE_SAT  = 255;
    localparam int unsigned SLOT_IDX_W   = 4;
    localparam int unsigned CORNER_IDX_W = 2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OPEN,
        ST_LOOK,
        ST_DECIDE,
        ST_INSERT,
        ST_VMUL,
        ST_VMOD,
        ST_VRD,
        ST_VCHK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                    capture;
        logic                    open_mesh;
        logic                    decide;
        logic                    bone_rd;
        logic                    bone_chk;
        logic                    insert;
        logic                    vmul;
        logic                    vmod;
        logic                    vrd;
        logic                    vchk;
        logic                    clr_step;
        logic [SLOT_IDX_W-1:0]   slot;
        logic [CORNER_IDX_W-1:0] corner;
    } t_cmd;

    typedef struct packed {
        logic serial_max;
        logic overflow;
        logic clr_last;
    } t_sts;

endpackage

// ----- rtl/bpmp_ctrl.sv -----
// Sequencer for the partitioner: walks the bone, vertex and clear phases.
// Depends on bpmp_pkg; drives bpmp_dp through t_cmd and reads back t_sts.
module bpmp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            i_mesh_start,
    input  bpmp_pkg::t_sts  i_sts,
    output bpmp_pkg::t_cmd  o_cmd,
    output logic            busy,
    output logic            o_done
);
    import bpmp_pkg::*;

    localparam logic [SLOT_IDX_W-1:0]   LAST_SLOT   = SLOT_IDX_W'(NUM_SLOTS - 1);
    localparam logic [SLOT_IDX_W-1:0]   LOOK_END    = SLOT_IDX_W'(NUM_SLOTS);
    localparam logic [CORNER_IDX_W-1:0] LAST_CORNER = CORNER_IDX_W'(NUM_CORNERS - 1);

    t_state                  r_state, n_state;
    logic [SLOT_IDX_W-1:0]   r_slot, n_slot;
    logic [CORNER_IDX_W-1:0] r_corner, n_corner;
    logic                    r_pend, n_pend;
    logic                    r_item, n_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_slot   <= '0;
            r_corner <= '0;
            r_pend   <= 1'b0;
            r_item   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_corner <= n_corner;
            r_pend   <= n_pend;
            r_item   <= n_item;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_corner = r_corner;
        n_pend   = r_pend;
        n_item   = r_item;
        o_cmd    = '0;
        o_cmd.slot   = r_slot;
        o_cmd.corner = r_corner;
        busy     = 1'b1;
        o_done   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_item ? ST_VMUL : ST_IDLE;
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_item  = 1'b1;
                    n_slot  = '0;
                    n_state = i_mesh_start ? ST_OPEN : ST_LOOK;
                end
            end
            ST_OPEN: begin
                o_cmd.open_mesh = 1'b1;
                if (i_sts.serial_max) begin
                    n_pend = 1'b1;
                end
                n_state = ST_LOOK;
            end
            ST_LOOK: begin
                // issue one read per cycle; check the previous slot's data
                o_cmd.bone_rd  = (r_slot != LOOK_END);
                o_cmd.bone_chk = (r_slot != '0);
                if (r_slot == LOOK_END) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_sts.overflow && i_sts.serial_max) begin
                    n_pend = 1'b1;
                end
                n_slot  = '0;
                n_state = ST_INSERT;
            end
            ST_INSERT: begin
                o_cmd.insert = 1'b1;
                if (r_slot == LAST_SLOT) begin
                    n_corner = '0;
                    if (r_pend) begin
                        n_pend  = 1'b0;
                        n_state = ST_CLEAR;
                    end else begin
                        n_state = ST_VMUL;
                    end
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ST_VMUL: begin
                o_cmd.vmul = 1'b1;
                n_state = ST_VMOD;
            end
            ST_VMOD: begin
                o_cmd.vmod = 1'b1;
                n_state = ST_VRD;
            end
            ST_VRD: begin
                o_cmd.vrd = 1'b1;
                n_state = ST_VCHK;
            end
            ST_VCHK: begin
                o_cmd.vchk = 1'b1;
                if (r_corner == LAST_CORNER) begin
                    n_state = ST_DONE;
                end else begin
                    n_corner = r_corner + 1'b1;
                    n_state  = ST_VMUL;
                end
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_item  = 1'b0;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/bpmp_dp.sv -----
// Datapath of the partitioner: bone map, vertex map, counters and result words.
// Depends on bpmp_pkg; sequenced by bpmp_ctrl through t_cmd.
module bpmp_dp #(
    parameter int unsigned MAX_VERTICES     = 65536,
    parameter int unsigned GLOBAL_BONES     = 256,
    parameter int unsigned SLOTS_PER_VERTEX = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bpmp_pkg::t_cmd       i_cmd,
    output bpmp_pkg::t_sts       o_sts,
    input  logic                 i_cfg_valid,
    input  logic [7:0]           i_cfg_data,
    input  logic [15:0]          i_vertex_index_0,
    input  logic [15:0]          i_vertex_index_1,
    input  logic [15:0]          i_vertex_index_2,
    input  logic [31:0]          i_global_bones_0,
    input  logic [31:0]          i_global_bones_1,
    input  logic [31:0]          i_global_bones_2,
    input  logic [3:0]           i_weight_mask_0,
    input  logic [3:0]           i_weight_mask_1,
    input  logic [3:0]           i_weight_mask_2,
    output logic [15:0]          o_chunk_number,
    output logic                 o_chunk_opened,
    output logic [15:0]          o_new_index_0,
    output logic [15:0]          o_new_index_1,
    output logic [15:0]          o_new_index_2,
    output logic [2:0]           o_vertex_added_mask,
    output logic [31:0]          o_local_bones_0,
    output logic [31:0]          o_local_bones_1,
    output logic [31:0]          o_local_bones_2,
    output logic [7:0]           o_palette_size
);
    import bpmp_pkg::*;

    localparam int unsigned BAW      = $clog2(GLOBAL_BONES);
    localparam int unsigned VAW      = $clog2(MAX_VERTICES);
    localparam int unsigned USE_SLOT = (SLOTS_PER_VERTEX < SLOT_LANES) ?
                                       SLOTS_PER_VERTEX : SLOT_LANES;
    localparam bit          V_FOLD   = (MAX_VERTICES < 65536);
    localparam int unsigned V_RECIP  = 65536 / MAX_VERTICES;
    localparam int unsigned CNT_W    = $clog2(NUM_SLOTS + 1);
    localparam int unsigned VENT_W   = 1 + SERIAL_W + 16;
    localparam int unsigned BENT_W   = SERIAL_W + LOCAL_W;

    // bone ID folding table, built at elaboration
    logic [BAW-1:0] w_bmod [256];
    for (genvar g = 0; g < 256; g++) begin : g_bmod
        assign w_bmod[g] = BAW'(g % GLOBAL_BONES);
    end

    // configuration
    logic [7:0] r_limit;
    logic [7:0] w_limit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 8'(LIMIT_RESET);
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end
    assign w_limit = (r_limit > 8'(PALETTE_CAP)) ? 8'(PALETTE_CAP) : r_limit;

    // captured triangle
    logic [15:0]           r_vidx  [NUM_CORNERS];
    logic [BAW-1:0]        r_bm    [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  r_used;
    logic [NUM_SLOTS-1:0]  r_uniq;
    logic [SLOT_IDX_W-1:0] r_first [NUM_SLOTS];
    logic [LOCAL_W-1:0]    r_loc   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  r_hit;

    logic [BAW-1:0]        w_bm    [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  w_used;
    logic [NUM_SLOTS-1:0]  w_uniq;
    logic [SLOT_IDX_W-1:0] w_first [NUM_SLOTS];
    logic [31:0]           w_gb    [NUM_CORNERS];
    logic [3:0]            w_wm    [NUM_CORNERS];

    assign w_gb[0] = i_global_bones_0;
    assign w_gb[1] = i_global_bones_1;
    assign w_gb[2] = i_global_bones_2;
    assign w_wm[0] = i_weight_mask_0;
    assign w_wm[1] = i_weight_mask_1;
    assign w_wm[2] = i_weight_mask_2;

    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            w_bm[s]   = w_bmod[w_gb[s / SLOT_LANES][8 * (s % SLOT_LANES) +: 8]];
            w_used[s] = w_wm[s / SLOT_LANES][s % SLOT_LANES] &&
                        ((s % SLOT_LANES) < USE_SLOT);
        end
        // first earlier used slot holding the same bone
        for (int s = 0; s < NUM_SLOTS; s++) begin
            w_first[s] = SLOT_IDX_W'(s);
            w_uniq[s]  = w_used[s];
            for (int t = NUM_SLOTS - 1; t >= 0; t--) begin
                if (t < s && w_used[t] && w_bm[t] == w_bm[s]) begin
                    w_first[s] = SLOT_IDX_W'(t);
                    w_uniq[s]  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_vidx[0] <= i_vertex_index_0;
            r_vidx[1] <= i_vertex_index_1;
            r_vidx[2] <= i_vertex_index_2;
            r_bm      <= w_bm;
            r_used    <= w_used;
            r_uniq    <= w_uniq;
            r_first   <= w_first;
        end
    end

    // chunk state
    logic [SERIAL_W-1:0]  r_serial;
    logic [15:0]          r_chunk;
    logic [7:0]           r_palette;
    logic [VCOUNT_W-1:0]  r_cvc;
    logic                 r_opened;
    logic [2:0]           r_added;
    logic [15:0]          r_newidx [NUM_CORNERS];
    logic [GLOBAL_BONES-1:0] r_bvalid;

    // bone map
    logic [BENT_W-1:0]    bmem [GLOBAL_BONES];
    logic [BENT_W-1:0]    r_bent;
    logic                 r_bvld_q;
    logic [SLOT_IDX_W-1:0] r_slot_d;
    logic                 w_bhit;
    logic [CNT_W-1:0]     w_need;
    logic                 w_over;
    logic                 w_ins;

    assign w_bhit = r_bvld_q && (r_bent[BENT_W-1 -: SERIAL_W] == r_serial);

    always_comb begin
        w_need = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            w_need = w_need + CNT_W'(r_uniq[s] && !r_hit[s]);
        end
    end
    assign w_over = (9'(r_palette) + 9'(w_need)) > 9'(w_limit);
    assign w_ins  = i_cmd.insert && r_uniq[i_cmd.slot] && !r_hit[i_cmd.slot];

    always_ff @(posedge i_clk) begin
        if (i_cmd.bone_rd) begin
            r_bent   <= bmem[r_bm[i_cmd.slot]];
            r_bvld_q <= r_bvalid[r_bm[i_cmd.slot]];
            r_slot_d <= i_cmd.slot;
        end
        if (w_ins) begin
            bmem[r_bm[i_cmd.slot]] <= {r_serial, r_palette[LOCAL_W-1:0]};
        end
    end

    // vertex map with clearing sweep
    logic [VENT_W-1:0] vmem [MAX_VERTICES];
    logic [VENT_W-1:0] r_vent;
    logic [VAW-1:0]    r_clr_addr;
    logic [VAW-1:0]    r_vaddr;
    logic [15:0]       r_vq;
    logic [15:0]       w_vcur;
    logic [31:0]       w_vprod;
    logic [31:0]       w_qm;
    logic [31:0]       w_rem;
    logic [31:0]       w_rem2;
    logic              w_vhit;
    logic              w_clr_last;

    assign w_vcur     = r_vidx[i_cmd.corner];
    assign w_vprod    = 32'(w_vcur) * 32'(V_RECIP);
    assign w_qm       = 32'(r_vq) * 32'(MAX_VERTICES);
    assign w_rem      = 32'(w_vcur) - w_qm;
    assign w_rem2     = (w_rem >= 32'(MAX_VERTICES)) ? (w_rem - 32'(MAX_VERTICES)) : w_rem;
    assign w_vhit     = r_vent[VENT_W-1] && (r_vent[VENT_W-2 -: SERIAL_W] == r_serial);
    assign w_clr_last = (r_clr_addr == VAW'(MAX_VERTICES - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.vmul) begin
            r_vq <= w_vprod[31:16];
        end
        if (i_cmd.vmod) begin
            r_vaddr <= V_FOLD ? VAW'(w_rem2) : VAW'(w_vcur);
        end
        if (i_cmd.vrd) begin
            r_vent <= vmem[r_vaddr];
        end
        if (i_cmd.clr_step) begin
            vmem[r_clr_addr] <= '0;
        end else if (i_cmd.vchk && !w_vhit) begin
            vmem[r_vaddr] <= {1'b1, r_serial, r_cvc[15:0]};
        end
    end

    // per-triangle payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opened <= 1'b0;
            r_added  <= '0;
            r_hit    <= '0;
        end
        if (i_cmd.open_mesh) begin
            r_opened <= 1'b1;
        end
        if (i_cmd.bone_chk) begin
            r_hit[r_slot_d] <= w_bhit;
            r_loc[r_slot_d] <= r_bent[LOCAL_W-1:0];
        end
        if (i_cmd.decide && w_over) begin
            r_opened <= 1'b1;
            r_hit    <= '0;
        end
        if (w_ins) begin
            r_loc[i_cmd.slot] <= r_palette[LOCAL_W-1:0];
        end else if (i_cmd.insert && r_used[i_cmd.slot] && !r_uniq[i_cmd.slot]) begin
            r_loc[i_cmd.slot] <= r_loc[r_first[i_cmd.slot]];
        end
        if (i_cmd.vchk) begin
            if (w_vhit) begin
                r_newidx[i_cmd.corner] <= r_vent[15:0];
            end else begin
                r_newidx[i_cmd.corner] <= r_cvc[15:0];
                r_added[i_cmd.corner]  <= 1'b1;
            end
        end
    end

    // chunk control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_serial   <= '0;
            r_chunk    <= '0;
            r_palette  <= '0;
            r_cvc      <= '0;
            r_bvalid   <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.open_mesh || (i_cmd.decide && w_over)) begin
                r_serial  <= r_serial + 1'b1;
                r_palette <= '0;
                r_cvc     <= '0;
                r_chunk   <= i_cmd.open_mesh ? '0 : r_chunk + 1'b1;
                if (r_serial == '1) begin
                    r_bvalid <= '0;
                end
            end
            if (w_ins) begin
                r_bvalid[r_bm[i_cmd.slot]] <= 1'b1;
                if (r_palette < 8'(PALETTE_SAT)) begin
                    r_palette <= r_palette + 1'b1;
                end
            end
            if (i_cmd.vchk && !w_vhit && r_cvc < VCOUNT_W'(VCOUNT_SAT)) begin
                r_cvc <= r_cvc + 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= w_clr_last ? '0 : r_clr_addr + 1'b1;
            end
        end
    end

    assign o_sts.serial_max = (r_serial == '1);
    assign o_sts.overflow   = w_over;
    assign o_sts.clr_last   = w_clr_last;

    // result word
    logic [31:0] w_lb [NUM_CORNERS];
    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            w_lb[s / SLOT_LANES][8 * (s % SLOT_LANES) +: 8] =
                r_used[s] ? {1'b0, r_loc[s]} : 8'd0;
        end
    end

    assign o_chunk_number      = r_chunk;
    assign o_chunk_opened      = r_opened;
    assign o_new_index_0       = r_newidx[0];
    assign o_new_index_1       = r_newidx[1];
    assign o_new_index_2       = r_newidx[2];
    assign o_vertex_added_mask = r_added;
    assign o_local_bones_0     = w_lb[0];
    assign o_local_bones_1     = w_lb[1];
    assign o_local_bones_2     = w_lb[2];
    assign o_palette_size      = r_palette;

endmodule

// ----- rtl/bone_palette_mesh_partitioner.sv -----
// Top level of the bone palette mesh partitioner.
// Depends on bpmp_pkg, bpmp_ctrl and bpmp_dp.
//
// Takes one skinned triangle per start pulse (accepted when start is high and
// busy is low) and returns one remapped word, shown for a single cycle with
// o_done high; the receiver cannot hold it off, so capture it on that cycle.
// A triangle keeps the block busy from acceptance through o_done (longer with
// mesh start), so a new triangle is accepted only after that. The busy time
// comes from the single-port bone map (twelve reads, then twelve insert
// writes) and the vertex map (fold, read, update for each of three corners).
// After reset, and whenever the 16-bit chunk serial wraps, the vertex map is
// swept clear at one entry per cycle, keeping the block busy. The bone_limit
// register may be written on the cfg channel at any idle time; values above
// 128 act as 128.
module bone_palette_mesh_partitioner #(
    parameter int unsigned MAX_VERTICES     = 65536,
    parameter int unsigned GLOBAL_BONES     = 256,
    parameter int unsigned SLOTS_PER_VERTEX = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_mesh_start,
    input  logic [15:0] i_vertex_index_0,
    input  logic [15:0] i_vertex_index_1,
    input  logic [15:0] i_vertex_index_2,
    input  logic [31:0] i_global_bones_0,
    input  logic [31:0] i_global_bones_1,
    input  logic [31:0] i_global_bones_2,
    input  logic [3:0]  i_weight_mask_0,
    input  logic [3:0]  i_weight_mask_1,
    input  logic [3:0]  i_weight_mask_2,
    output logic        o_done,
    output logic [15:0] o_chunk_number,
    output logic        o_chunk_opened,
    output logic [15:0] o_new_index_0,
    output logic [15:0] o_new_index_1,
    output logic [15:0] o_new_index_2,
    output logic [2:0]  o_vertex_added_mask,
    output logic [31:0] o_local_bones_0,
    output logic [31:0] o_local_bones_1,
    output logic [31:0] o_local_bones_2,
    output logic [7:0]  o_palette_size
);
    import bpmp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_cfg_we;

    // take a config word only while idle, so it never lands mid-triangle
    assign o_cfg_ready = !busy;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    bpmp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_mesh_start (i_mesh_start),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .busy         (busy),
        .o_done       (o_done)
    );

    bpmp_dp #(
        .MAX_VERTICES     (MAX_VERTICES),
        .GLOBAL_BONES     (GLOBAL_BONES),
        .SLOTS_PER_VERTEX (SLOTS_PER_VERTEX)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_cfg_valid         (w_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_vertex_index_0    (i_vertex_index_0),
        .i_vertex_index_1    (i_vertex_index_1),
        .i_vertex_index_2    (i_vertex_index_2),
        .i_global_bones_0    (i_global_bones_0),
        .i_global_bones_1    (i_global_bones_1),
        .i_global_bones_2    (i_global_bones_2),
        .i_weight_mask_0     (i_weight_mask_0),
        .i_weight_mask_1     (i_weight_mask_1),
        .i_weight_mask_2     (i_weight_mask_2),
        .o_chunk_number      (o_chunk_number),
        .o_chunk_opened      (o_chunk_opened),
        .o_new_index_0       (o_new_index_0),
        .o_new_index_1       (o_new_index_1),
        .o_new_index_2       (o_new_index_2),
        .o_vertex_added_mask (o_vertex_added_mask),
        .o_local_bones_0     (o_local_bones_0),
        .o_local_bones_1     (o_local_bones_1),
        .o_local_bones_2     (o_local_bones_2),
        .o_palette_size      (o_palette_size)
    );

endmodule
